// ----- hw/rtl/base64url_encoder_assert.svh -----
// Assertion macros for the base64url encoder.
// Used by the top level only; they compile away when SYNTHESIS is defined.
`ifndef BASE64URL_ENCODER_ASSERT_SVH
`define BASE64URL_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
`define B64U_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("b64u assertion failed");
`define B64U_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("b64u assertion failed");
`else
`define B64U_ASSERT(lbl, clk, rstn, prop)
`define B64U_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- hw/rtl/b64u_pkg.sv -----
// Shared types, constants and the symbol alphabet of the base64url encoder.
// No dependencies.
package b64u_pkg;

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = 1;
    localparam int unsigned Q_CNT_W = 2;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // up to four characters one input byte produces
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            last;
    } b64u_job_t;

    typedef struct packed {
        logic      valid;
        b64u_job_t job;
    } b64u_push_t;

    function automatic logic [7:0] sym_char(input logic [5:0] v);
        logic [7:0] c;
        c = 8'h00;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            c = 8'h2D;
        end else begin
            c = 8'h5F;
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/b64u_front.sv -----
// Front end: accepts message bytes, tracks the group position and builds the
// characters each byte produces. Depends on b64u_pkg.
module b64u_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,   // end_of_message
    input  logic                 q_full,
    output b64u_pkg::b64u_push_t push,
    output logic [1:0]           phase
);

    logic [1:0] phase_reg, phase_next;
    logic [3:0] left_reg, left_next;
    b64u_pkg::b64u_job_t job;
    logic take;

    // no request is taken while in reset
    assign s_tready = aresetn && !q_full;
    assign take     = s_tvalid && s_tready;
    assign phase    = phase_reg;

    always_comb begin
        job.chars    = {4{b64u_pkg::PAD_CHAR}};
        job.last_idx = 2'd0;
        job.last     = s_tlast;
        phase_next   = phase_reg;
        left_next    = left_reg;
        unique case (phase_reg)
            b64u_pkg::PH_SECOND: begin
                job.chars[0] = b64u_pkg::sym_char({left_reg[1:0], s_tdata[7:4]});
                if (s_tlast) begin
                    job.chars[1] = b64u_pkg::sym_char({s_tdata[3:0], 2'b00});
                    job.last_idx = 2'd2;
                    phase_next   = b64u_pkg::PH_FIRST;
                    left_next    = 4'd0;
                end else begin
                    phase_next   = b64u_pkg::PH_THIRD;
                    left_next    = s_tdata[3:0];
                end
            end
            b64u_pkg::PH_THIRD: begin
                job.chars[0] = b64u_pkg::sym_char({left_reg, s_tdata[7:6]});
                job.chars[1] = b64u_pkg::sym_char(s_tdata[5:0]);
                job.last_idx = 2'd1;
                phase_next   = b64u_pkg::PH_FIRST;
                left_next    = 4'd0;
            end
            default: begin
                // unused phase behaves as the start of a group
                job.chars[0] = b64u_pkg::sym_char(s_tdata[7:2]);
                if (s_tlast) begin
                    job.chars[1] = b64u_pkg::sym_char({s_tdata[1:0], 4'b0000});
                    job.last_idx = 2'd3;
                    phase_next   = b64u_pkg::PH_FIRST;
                    left_next    = 4'd0;
                end else begin
                    phase_next   = b64u_pkg::PH_SECOND;
                    left_next    = {2'b00, s_tdata[1:0]};
                end
            end
        endcase
    end

    assign push.valid = take;
    assign push.job   = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= b64u_pkg::PH_FIRST;
            left_reg  <= 4'd0;
        end else if (take) begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

// ----- hw/rtl/b64u_queue.sv -----
// Two-entry queue of character jobs between front and back end.
// Depends on b64u_pkg.
module b64u_queue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  b64u_pkg::b64u_push_t      push,
    input  logic                      pop,
    output logic                      full,
    output logic                      not_empty,
    output logic [b64u_pkg::Q_CNT_W-1:0] count,
    output b64u_pkg::b64u_job_t       head
);

    b64u_pkg::b64u_job_t mem [b64u_pkg::Q_DEPTH];
    logic [b64u_pkg::Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [b64u_pkg::Q_CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == b64u_pkg::Q_CNT_W'(b64u_pkg::Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push.valid && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push.valid && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push.valid) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)        rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// ----- hw/rtl/b64u_back.sv -----
// Back end: walks the characters of the queue head, one per cycle while the
// receiver is ready, into the output register. Depends on b64u_pkg.
module b64u_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_not_empty,
    input  b64u_pkg::b64u_job_t head,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // [7:0] out_char
    output logic                m_tlast    // last_char
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       load, at_end;

    assign load   = q_not_empty && (!valid_reg || m_tready);
    assign at_end = (idx_reg == head.last_idx);
    assign pop    = load && at_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg   <= at_end ? 2'd0 : idx_reg + 1'b1;
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= head.chars[idx_reg];
            last_reg <= at_end && head.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

// ----- hw/rtl/base64url_encoder.sv -----
// Top level of the base64url encoder (URL-safe alphabet, '=' padding).
// Depends on b64u_pkg, b64u_front, b64u_queue, b64u_back and the assert header.
//
// Input stream: one message byte per request on s_tdata, s_tlast on the final
// byte of a message. Output stream: one ASCII character per request on
// m_tdata, m_tlast on the final character of the encoded message.
// Each byte yields one to four characters; every message yields a multiple
// of four characters.
// A taken byte is written into the job queue; its first character is then
// registered from the queue head into the output register.
// Throughput: one character per cycle while the receiver is ready, set by the
// single output register; a byte yields 4/3 characters on average over
// whole groups. The front end takes a byte every cycle while the two-entry
// job queue has room.
// Reset clears the group position, the queue and the output valid flag;
// s_tready is low during reset and rises with aresetn.
// If the receiver stalls, the output holds; the queue fills and s_tready
// falls within two further bytes.
`include "base64url_encoder_assert.svh"

module base64url_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // end_of_message
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast    // last_char
);

    b64u_pkg::b64u_push_t push;
    b64u_pkg::b64u_job_t  head;
    logic                 q_full, q_not_empty, pop;
    logic [b64u_pkg::Q_CNT_W-1:0] q_count;
    logic [1:0]           phase;
    logic                 fin_take, out_idle;

    b64u_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .phase    (phase)
    );

    b64u_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .count     (q_count),
        .head      (head)
    );

    b64u_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .head        (head),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    assign fin_take = s_tvalid && s_tready && s_tlast;
    assign out_idle = !q_not_empty && (!m_tvalid || m_tready);

    // a final byte always returns the group to its start
    `B64U_ASSERT(a_final_resets_group, aclk, aresetn, fin_take |=> phase == b64u_pkg::PH_FIRST)
    // queue never overfills
    `B64U_ASSERT(a_queue_bound, aclk, aresetn, q_count <= b64u_pkg::Q_CNT_W'(b64u_pkg::Q_DEPTH))
    // no character appears without a queued job
    `B64U_ASSERT(a_no_spurious_out, aclk, aresetn, out_idle |=> !m_tvalid)

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for base64url_encoder: byte requests in, character requests out.
// Depends on b64u_pkg and the encoder RTL. A predictor tracks the group position
// and the carried bits, and each character is checked in order against it.
module testbench;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam logic [8*64-1:0] URL_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_req_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_req_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] data_byte
    logic       s_tlast  = 1'b0;    // end_of_message
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_char
    logic       m_tlast;            // last_char

    byte_req_t   pending_bytes[$];
    char_req_t   expected_chars[$];
    logic [1:0]  grp_phase  = b64u_pkg::PH_FIRST;
    logic [3:0]  carry_bits = 4'h0;
    int unsigned idle_pct   = 0;
    int unsigned stall_pct  = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    base64url_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [7:0] url_char(input logic [5:0] v);
        return URL_ALPHABET[8*(63 - int'(v)) +: 8];
    endfunction

    // append one expected character at the tail
    task automatic expect_char(input logic [7:0] ch, input logic last);
        char_req_t item;
        item.ch   = ch;
        item.last = last;
        expected_chars.insert(expected_chars.size(), item);
    endtask

    // expected characters for one accepted byte; updates the group state
    task automatic predict_chars(input logic [7:0] b, input logic fin);
        case (grp_phase)
            b64u_pkg::PH_SECOND: begin
                expect_char(url_char({carry_bits[1:0], b[7:4]}), 1'b0);
                if (fin) begin
                    expect_char(url_char({b[3:0], 2'b00}), 1'b0);
                    expect_char(b64u_pkg::PAD_CHAR, 1'b1);
                    grp_phase  = b64u_pkg::PH_FIRST;
                    carry_bits = 4'h0;
                end else begin
                    grp_phase  = b64u_pkg::PH_THIRD;
                    carry_bits = b[3:0];
                end
            end
            b64u_pkg::PH_THIRD: begin
                expect_char(url_char({carry_bits, b[7:6]}), 1'b0);
                expect_char(url_char(b[5:0]), fin);
                grp_phase  = b64u_pkg::PH_FIRST;
                carry_bits = 4'h0;
            end
            default: begin
                // a stray phase of 3 counts as the start of a group
                expect_char(url_char(b[7:2]), 1'b0);
                if (fin) begin
                    expect_char(url_char({b[1:0], 4'h0}), 1'b0);
                    expect_char(b64u_pkg::PAD_CHAR, 1'b0);
                    expect_char(b64u_pkg::PAD_CHAR, 1'b1);
                    grp_phase  = b64u_pkg::PH_FIRST;
                    carry_bits = 4'h0;
                end else begin
                    grp_phase  = b64u_pkg::PH_SECOND;
                    carry_bits = {2'b00, b[1:0]};
                end
            end
        endcase
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic fin);
        byte_req_t item;
        item.data = b;
        item.last = fin;
        pending_bytes.insert(pending_bytes.size(), item);
    endtask

    task automatic queue_random_messages(input int target);
        int count;
        int len;
        logic [7:0] b;
        count = 0;
        while (count < target) begin
            len = ($urandom_range(4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(9))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom_range(255));
                endcase
                queue_byte(b, i == len - 1);
            end
            count += len;
        end
    endtask

    // driver: hold a request until taken, otherwise offer the next byte or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_chars(s_tdata, s_tlast);
                void'(pending_bytes.pop_front());
            end
            if (s_tvalid && !s_tready) begin
                // stalled, keep the request as it is
            end else if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_bytes[0].data;
                s_tlast  <= pending_bytes[0].last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compare each taken character with the oldest expectation
    always @(posedge aclk) begin : watch
        char_req_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            if (aresetn && m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    $error("out_char: expected nothing, got %h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (m_tdata !== want.ch) begin
                        $error("out_char: expected %h, got %h", want.ch, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_char: expected %b, got %b", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // single-byte messages, incl. the '-' and '_' symbols
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hFB, 1'b1);
        // two bytes: one '=' of padding
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b1);
        // whole groups, no padding
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFB, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hBF, 1'b1);
        // group crossings, ending mid-group
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h02, 1'b0);
        queue_byte(8'h03, 1'b0);
        queue_byte(8'h04, 1'b1);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h40, 1'b0);
        queue_byte(8'h20, 1'b0);
        queue_byte(8'h10, 1'b0);
        queue_byte(8'h08, 1'b1);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 62; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            queue_random_messages(90);
            while (pending_bytes.size() != 0) @(negedge aclk);
        end

        while (pending_bytes.size() != 0 || expected_chars.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
